/* rtl/nsrg_pkg.sv */
package nsrg_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // take the offered input item
        logic place;    // store key in memory, hole or reservoir
        logic scan;     // run the minimum search over the slot memory
        logic emit;     // commit the found minimum as a result
        logic close;    // mark the newest result as closing its run
        logic move;     // copy the reservoir into the slot memory
        logic clear;    // return all run state to its reset values
        logic finish;   // release the held result with item_done set
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fill_phase;    // memory not yet filled for the first time
        logic fill_last;     // this key completes the initial fill
        logic below;         // key is below the last emitted key
        logic res_fill;      // storing this key fills the reservoir
        logic eoi;           // item carries the end mark
        logic any_valid;     // at least one slot holds a key
        logic res_nonempty;  // reservoir holds at least one key
        logic scan_done;     // minimum search result settles this cycle
        logic move_done;     // reservoir copy complete
        logic emit_ok;       // a new result can be taken into the holding stage
    } stat_t;

endpackage

/* rtl/nsrg_ram.sv */
module nsrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/nsrg_ctrl.sv */
module nsrg_ctrl
    import nsrg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLACE,
        S_CHECK,
        S_SCAN,
        S_EMIT,
        S_MOVE,
        S_CLEAR,
        S_FINISH
    } state_t;

    // What the current emit or drain belongs to
    typedef enum logic [1:0] {
        M_ONE,      // single emit, then end-mark check
        M_RES,      // drain before the reservoir takes over memory
        M_FLUSH1,   // end flush of memory
        M_FLUSH2    // end flush of the former reservoir
    } mode_t;

    state_t state_reg;
    mode_t  mode_reg;

    // State and mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= M_ONE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_PLACE;
                    end
                end
                S_PLACE:
                begin
                    if (st.fill_phase && st.fill_last)
                    begin
                        mode_reg  <= M_ONE;
                        state_reg <= S_SCAN;
                    end
                    else if (!st.fill_phase && !st.below)
                    begin
                        mode_reg  <= M_ONE;
                        state_reg <= S_SCAN;
                    end
                    else if (!st.fill_phase && st.res_fill)
                    begin
                        mode_reg  <= M_RES;
                        state_reg <= S_CHECK;
                    end
                    else if (st.eoi)
                    begin
                        mode_reg  <= M_FLUSH1;
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_CHECK:
                begin
                    if (st.any_valid)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        case (mode_reg)
                            M_RES:
                            begin
                                state_reg <= S_MOVE;
                            end
                            M_FLUSH1:
                            begin
                                if (st.res_nonempty)
                                begin
                                    mode_reg  <= M_FLUSH2;
                                    state_reg <= S_MOVE;
                                end
                                else
                                begin
                                    state_reg <= S_CLEAR;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_CLEAR;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (st.scan_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (st.emit_ok)
                    begin
                        if (mode_reg != M_ONE)
                        begin
                            state_reg <= S_CHECK;
                        end
                        else if (st.eoi)
                        begin
                            mode_reg  <= M_FLUSH1;
                            state_reg <= S_CHECK;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_MOVE:
                begin
                    if (st.move_done)
                    begin
                        if (mode_reg == M_RES)
                        begin
                            mode_reg  <= M_ONE;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CLEAR:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (st.emit_ok)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Command decode
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:   cmd.load   = in_valid;
            S_PLACE:  cmd.place  = 1'b1;
            S_CHECK:  cmd.close  = !st.any_valid;
            S_SCAN:   cmd.scan   = 1'b1;
            S_EMIT:   cmd.emit   = 1'b1;
            S_MOVE:   cmd.move   = 1'b1;
            S_CLEAR:  cmd.clear  = 1'b1;
            S_FINISH: cmd.finish = 1'b1;
            default:  cmd        = '0;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

/* rtl/nsrg_dp.sv */
module nsrg_dp
    import nsrg_pkg::*;
#(
    parameter int MEM_SLOTS = 8,
    parameter int RES_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              st,
    input  logic signed [31:0] value,
    input  logic               end_of_input,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value_res,
    output logic               run_end,
    output logic               item_done
);

    localparam int RES_CAP = (RES_SLOTS < MEM_SLOTS) ? RES_SLOTS : MEM_SLOTS;
    localparam int IDXW    = $clog2(MEM_SLOTS);
    localparam int FCW     = $clog2(MEM_SLOTS + 1);
    localparam int RAW     = (RES_CAP > 1) ? $clog2(RES_CAP) : 1;
    localparam int RCW     = $clog2(RES_CAP + 1);

    localparam logic [FCW-1:0]  SLOT_END  = FCW'(MEM_SLOTS);
    localparam logic [FCW-1:0]  SLOT_LAST = FCW'(MEM_SLOTS - 1);
    localparam logic [IDXW-1:0] IDX_LAST  = IDXW'(MEM_SLOTS - 1);
    localparam logic [RCW-1:0]  RES_FULL  = RCW'(RES_CAP);
    localparam logic [RCW-1:0]  RES_LAST  = RCW'(RES_CAP - 1);

    // Item and run state
    logic signed [31:0]   v_reg;
    logic                 eoi_reg;
    logic [FCW-1:0]       fill_cnt_reg;
    logic [RCW-1:0]       res_cnt_reg;
    logic signed [31:0]   last_reg;
    logic [IDXW-1:0]      hole_reg;
    logic [MEM_SLOTS-1:0] slot_valid_reg;

    // Minimum search
    logic [FCW-1:0]       scan_cnt_reg;
    logic                 rd_v_reg;
    logic [IDXW-1:0]      rd_idx_reg;
    logic                 found_reg;
    logic signed [31:0]   best_reg;
    logic [IDXW-1:0]      best_idx_reg;

    // Reservoir copy
    logic [RCW-1:0]       mv_cnt_reg;
    logic                 mv_wr_reg;
    logic [IDXW-1:0]      mv_idx_reg;

    // Holding stage for the newest result and the output register
    logic                 pend_valid_reg;
    logic signed [31:0]   pend_value_reg;
    logic                 pend_run_end_reg;
    logic                 pend_in_run_reg;
    logic                 out_valid_reg;
    logic signed [31:0]   value_res_reg;
    logic                 run_end_reg;
    logic                 item_done_reg;

    // Memory ports
    logic                 slot_we;
    logic [IDXW-1:0]      slot_waddr;
    logic [31:0]          slot_wdata;
    logic [IDXW-1:0]      slot_raddr;
    logic [31:0]          slot_rdata;
    logic                 res_we;
    logic [RAW-1:0]       res_raddr;
    logic [31:0]          res_rdata;

    logic fill_phase;
    logic below;
    logic scan_issue;
    logic scan_start;
    logic hit;
    logic mv_issue;
    logic move_done;
    logic out_free;
    logic emit_ok;
    logic do_emit;
    logic do_finish;
    logic load_out;

    // Status
    assign fill_phase = (fill_cnt_reg < SLOT_END);
    assign below      = (v_reg < last_reg);
    assign move_done  = (mv_cnt_reg >= res_cnt_reg) && !mv_wr_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign emit_ok    = !pend_valid_reg || out_free;

    always_comb
    begin
        st              = '0;
        st.fill_phase   = fill_phase;
        st.fill_last    = (fill_cnt_reg == SLOT_LAST);
        st.below        = below;
        st.res_fill     = (res_cnt_reg == RES_LAST);
        st.eoi          = eoi_reg;
        st.any_valid    = |slot_valid_reg;
        st.res_nonempty = (res_cnt_reg != '0);
        st.scan_done    = rd_v_reg && (rd_idx_reg == IDX_LAST);
        st.move_done    = move_done;
        st.emit_ok      = emit_ok;
    end

    // Slot memory write: placement or reservoir copy
    assign slot_we    = (cmd.place && (fill_phase || !below)) || mv_wr_reg;
    assign slot_waddr = mv_wr_reg ? mv_idx_reg :
                        (fill_phase ? fill_cnt_reg[IDXW-1:0] : hole_reg);
    assign slot_wdata = mv_wr_reg ? res_rdata : v_reg;

    assign scan_issue = cmd.scan && (scan_cnt_reg < SLOT_END);
    assign scan_start = cmd.scan && (scan_cnt_reg == '0);
    assign slot_raddr = scan_issue ? scan_cnt_reg[IDXW-1:0] : '0;

    // Reservoir write on a low key, read during the copy
    assign res_we    = cmd.place && !fill_phase && below && (res_cnt_reg < RES_FULL);
    assign mv_issue  = cmd.move && (mv_cnt_reg < res_cnt_reg);
    assign res_raddr = mv_issue ? RAW'(mv_cnt_reg) : '0;

    nsrg_ram #(
        .WIDTH (32),
        .DEPTH (MEM_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_addr (slot_raddr),
        .rd_data (slot_rdata)
    );

    nsrg_ram #(
        .WIDTH (32),
        .DEPTH (RES_CAP)
    ) u_res_ram (
        .clk     (clk),
        .wr_en   (res_we),
        .wr_addr (RAW'(res_cnt_reg)),
        .wr_data (v_reg),
        .rd_addr (res_raddr),
        .rd_data (res_rdata)
    );

    // Search compare; strict less keeps the lowest index on ties
    assign hit = rd_v_reg && slot_valid_reg[rd_idx_reg] &&
                 (!found_reg || ($signed(slot_rdata) < best_reg));

    assign do_emit   = cmd.emit && emit_ok && found_reg;
    assign do_finish = cmd.finish && emit_ok;
    assign load_out  = (do_emit || do_finish) && pend_valid_reg;

    // Input item latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg <= value;
        end
    end

    // Control and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eoi_reg        <= 1'b0;
            fill_cnt_reg   <= '0;
            res_cnt_reg    <= '0;
            last_reg       <= '0;
            hole_reg       <= '0;
            slot_valid_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                eoi_reg <= end_of_input;
            end

            if (cmd.clear)
            begin
                fill_cnt_reg   <= '0;
                res_cnt_reg    <= '0;
                last_reg       <= '0;
                hole_reg       <= '0;
                slot_valid_reg <= '0;
            end
            else
            begin
                if (cmd.place && fill_phase)
                begin
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                end

                if (res_we)
                begin
                    res_cnt_reg <= res_cnt_reg + 1'b1;
                end
                else if (cmd.move && move_done)
                begin
                    res_cnt_reg <= '0;
                end

                if (slot_we)
                begin
                    slot_valid_reg[slot_waddr] <= 1'b1;
                end

                if (do_emit)
                begin
                    slot_valid_reg[best_idx_reg] <= 1'b0;
                    hole_reg                     <= best_idx_reg;
                    last_reg                     <= best_reg;
                end
            end
        end
    end

    // Search and copy sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            rd_v_reg     <= 1'b0;
            found_reg    <= 1'b0;
            mv_cnt_reg   <= '0;
            mv_wr_reg    <= 1'b0;
        end
        else
        begin
            if (!cmd.scan)
            begin
                scan_cnt_reg <= '0;
            end
            else if (scan_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            rd_v_reg <= scan_issue;

            if (scan_start)
            begin
                found_reg <= 1'b0;
            end
            else if (hit)
            begin
                found_reg <= 1'b1;
            end

            if (!cmd.move)
            begin
                mv_cnt_reg <= '0;
            end
            else if (mv_issue)
            begin
                mv_cnt_reg <= mv_cnt_reg + 1'b1;
            end
            mv_wr_reg <= mv_issue;
        end
    end

    // Search and copy payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= slot_raddr;
        mv_idx_reg <= IDXW'(mv_cnt_reg);
        if (hit)
        begin
            best_reg     <= $signed(slot_rdata);
            best_idx_reg <= rd_idx_reg;
        end
    end

    // Holding stage: flags settle once the next result or the end is known
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            pend_in_run_reg <= 1'b0;
        end
        else if (do_emit)
        begin
            pend_valid_reg  <= 1'b1;
            pend_in_run_reg <= 1'b1;
        end
        else if (do_finish)
        begin
            pend_valid_reg  <= 1'b0;
            pend_in_run_reg <= 1'b0;
        end
        else if (cmd.close)
        begin
            pend_in_run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            pend_value_reg   <= best_reg;
            pend_run_end_reg <= 1'b0;
        end
        else if (cmd.close && pend_valid_reg && pend_in_run_reg)
        begin
            pend_run_end_reg <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            value_res_reg <= pend_value_reg;
            run_end_reg   <= pend_run_end_reg;
            item_done_reg <= do_finish;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_res = value_res_reg;
    assign run_end   = run_end_reg;
    assign item_done = item_done_reg;

endmodule

/* rtl/natural_selection_run_generator.sv */
// Natural selection run generator for an external sort.
// Input channel (in_valid/in_ready) takes one key per item with an end mark;
// output channel (out_valid/out_ready) returns the keys of ascending runs,
// each result flagged with run_end on the key that closes a run and
// item_done on the last result caused by an input item.
// One item is worked on at a time; in_ready is high only while idle, and a
// finished result may still wait in the output register while the next item
// is taken.
// Per item: the key is placed, then for every result a minimum search runs
// over the slot memory (one slot read per cycle from the registered-read
// slot RAM) before the result is committed and the controller loops; a
// reservoir copy follows when a run ends, a clear after an end mark, then the
// last result is released and the block returns to idle to take the next item.
// Reset clears the slot valid bits and counters at once; no clearing pass.
// When the receiver stalls, the block holds its newest result and waits
// before producing another; no result is lost or repeated.
module natural_selection_run_generator
    import nsrg_pkg::*;
#(
    parameter int MEM_SLOTS = 8,
    parameter int RES_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] value,
    input  logic               end_of_input,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value_res,
    output logic               run_end,
    output logic               item_done
);

    cmd_t  cmd;
    stat_t st;

    nsrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    nsrg_dp #(
        .MEM_SLOTS (MEM_SLOTS),
        .RES_SLOTS (RES_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .value        (value),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value_res    (value_res),
        .run_end      (run_end),
        .item_done    (item_done)
    );

endmodule

/* rtl/nsrg_checker.sv */
module nsrg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] value_res,
    input logic               run_end,
    input logic               item_done
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_res) &&
        $stable(run_end) && $stable(item_done))
        else $error("stalled result changed");

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    // A result that is not the last of its item means the item is still in work
    a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !item_done |-> !in_ready)
        else $error("idle with an unfinished item on the output");

endmodule

bind natural_selection_run_generator nsrg_checker u_nsrg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .run_end   (run_end),
    .item_done (item_done)
);
